// ===== rtl/core/sst_pkg.sv =====
package sst_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam int KEY_W = 24;
  localparam int TIME_W = 32;
  localparam int LIFE_W = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [LIFE_W-1:0] LIFETIME_RESET = 16'd300;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_END = 2'd2;

  localparam logic REG_LIFETIME = 1'b0;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] net_number;
    logic [7:0] station_number;
    logic [7:0] port_number;
    logic [31:0] now_seconds;
  } in_item_t;

  typedef struct packed {
    logic success;
    logic expired;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic skip;
    logic hit;
    logic last;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/core/sst_dp.sv =====
module sst_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  sst_pkg::dp_cmd_t                   cmd,
  output sst_pkg::dp_status_t                status,
  input  sst_pkg::in_item_t                  in_item,
  input  logic [sst_pkg::LIFE_W-1:0]         session_lifetime,
  output logic                               out_valid,
  input  logic                               out_ready,
  output sst_pkg::out_item_t                 out_item
);
  import sst_pkg::*;

  logic [KEY_W-1:0]  key_mem [TABLE_ENTRIES];
  logic [TIME_W-1:0] dl_mem  [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid;

  in_item_t          item;
  logic [CNT_W-1:0]  cnt;
  logic              rd_vld;
  logic [IDX_W-1:0]  rd_idx;
  logic [KEY_W-1:0]  rd_key;
  logic [TIME_W-1:0] rd_deadline;
  out_item_t         res;

  logic [KEY_W-1:0]  item_key;
  logic [KEY_W-1:0]  target;
  logic              bad_op;
  logic              issue;
  logic [IDX_W-1:0]  rd_addr;
  logic              found;
  logic              live;
  logic              wr_en;
  logic [KEY_W-1:0]  wr_key;
  logic [TIME_W-1:0] wr_dl;
  out_item_t         res_next;

  assign item_key = {item.net_number, item.station_number, item.port_number};
  // a start looks for a free entry, the others for the key itself
  assign target = (item.operation == OP_START) ? '0 : item_key;
  assign bad_op = (item.operation != OP_START) && (item.operation != OP_LOOKUP) &&
                  (item.operation != OP_END);
  assign issue = cmd.scan && (cnt < CNT_W'(TABLE_ENTRIES));
  assign rd_addr = cnt[IDX_W-1:0];
  assign found = rd_vld && (rd_key == target) && !status.skip;
  assign live = item.now_seconds <= rd_deadline;

  assign status.skip = (item_key == '0) || bad_op;
  assign status.hit = found;
  assign status.last = rd_vld && (rd_idx == IDX_W'(TABLE_ENTRIES - 1));
  assign status.out_free = !out_valid || out_ready;

  always_comb begin
    wr_en = 1'b0;
    wr_key = '0;
    wr_dl = '0;
    res_next = '0;
    if (found) begin
      case (item.operation)
        OP_START: begin
          wr_en = 1'b1;
          wr_key = item_key;
          wr_dl = item.now_seconds + TIME_W'(session_lifetime);
          res_next.success = 1'b1;
        end
        OP_LOOKUP: begin
          if (live) begin
            res_next.success = 1'b1;
          end else begin
            wr_en = 1'b1;
            res_next.expired = 1'b1;
          end
        end
        OP_END: begin
          wr_en = 1'b1;
          res_next.success = 1'b1;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      cnt <= '0;
      rd_vld <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        cnt <= '0;
        rd_vld <= 1'b0;
      end else if (cmd.scan) begin
        rd_vld <= issue;
        if (issue) begin
          cnt <= cnt + 1'b1;
        end
      end
      if (cmd.commit && wr_en) begin
        valid[rd_idx] <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // never-written entries read as free with a zero deadline
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_item;
    end
    if (issue) begin
      rd_idx <= rd_addr;
      rd_key <= valid[rd_addr] ? key_mem[rd_addr] : '0;
      rd_deadline <= valid[rd_addr] ? dl_mem[rd_addr] : '0;
    end
    if (cmd.commit && wr_en) begin
      key_mem[rd_idx] <= wr_key;
      dl_mem[rd_idx] <= wr_dl;
    end
    if (cmd.commit) begin
      res <= res_next;
    end
    if (cmd.emit) begin
      out_item <= res;
    end
  end

endmodule

// ===== rtl/core/sst_ctrl.sv =====
module sst_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sst_pkg::dp_status_t   status,
  output sst_pkg::dp_cmd_t      cmd
);
  import sst_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.skip || status.hit || status.last) begin
          cmd.commit = 1'b1;
          state_next = ST_DONE;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/session_table_with_expiry.sv =====
// Session table of TABLE_ENTRIES entries keyed by net, station and port, each with a 32-bit
// deadline; the table is empty after reset. Start takes the lowest free entry with deadline
// now + session_lifetime, lookup reports a live session or clears and reports an expired one,
// end clears the lowest matching entry. One item is worked at a time: the table is scanned
// one entry per cycle through a single registered read port, from entry 0 up to the first match
// or the last entry; a zero key or an unused operation ends the item without a scan. The result
// then waits while the previous result item is still held by a low out_ready. session_lifetime
// sits at byte address 0 of the register port; the user must write it only while the block is
// idle, and the block itself does not enforce this.
module session_table_with_expiry (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  sst_pkg::in_item_t                 in_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output sst_pkg::out_item_t                out_item,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sst_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [sst_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [sst_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import sst_pkg::*;

  logic [LIFE_W-1:0] session_lifetime;
  dp_cmd_t           cmd;
  dp_status_t        status;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LIFETIME) ? CFG_DATA_W'(session_lifetime) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      session_lifetime <= LIFETIME_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_LIFETIME)) begin
      session_lifetime <= pwdata[LIFE_W-1:0];
    end
  end

  sst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  sst_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .in_item          (in_item),
    .session_lifetime (session_lifetime),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_item         (out_item)
  );

endmodule

// ===== bench/session_table_with_expiry_test.sv =====
module session_table_with_expiry_test;
  import sst_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int POOL_SIZE = 24;
  localparam int PHASE_ITEMS = 260;
  localparam int SETTLE_CYCLES = TABLE_ENTRIES + 8;

  // mirrors the session table and queues the expected outcome of every accepted item
  class session_scoreboard;
    logic [KEY_W-1:0]  keys [TABLE_ENTRIES];
    logic [TIME_W-1:0] deadlines [TABLE_ENTRIES];
    logic [LIFE_W-1:0] lifetime;
    out_item_t         outcome_q [$];
    int unsigned       faults, items, opened, refused, live, expiries, ended;

    function new();
      foreach (keys[i]) begin
        keys[i] = '0;
        deadlines[i] = '0;
      end
      lifetime = LIFETIME_RESET;
    endfunction

    function int find_entry(logic [KEY_W-1:0] key);
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (keys[i] == key) return i;
      end
      return -1;
    endfunction

    function void note_item(in_item_t item);
      logic [KEY_W-1:0] key;
      out_item_t outcome;
      int slot;
      key = {item.net_number, item.station_number, item.port_number};
      outcome = '0;
      items++;
      // the zero key marks a free entry and never names a session
      if (key != '0) begin
        case (item.operation)
          OP_START: begin
            slot = find_entry('0);
            if (slot >= 0) begin
              keys[slot] = key;
              deadlines[slot] = item.now_seconds + TIME_W'(lifetime);
              outcome.success = 1'b1;
              opened++;
            end else begin
              refused++;
            end
          end
          OP_LOOKUP: begin
            slot = find_entry(key);
            if (slot >= 0) begin
              if (item.now_seconds <= deadlines[slot]) begin
                outcome.success = 1'b1;
                live++;
              end else begin
                keys[slot] = '0;
                deadlines[slot] = '0;
                outcome.expired = 1'b1;
                expiries++;
              end
            end
          end
          OP_END: begin
            slot = find_entry(key);
            if (slot >= 0) begin
              keys[slot] = '0;
              deadlines[slot] = '0;
              outcome.success = 1'b1;
              ended++;
            end
          end
          default: ;
        endcase
      end
      outcome_q.push_back(outcome);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (outcome_q.size() == 0) begin
        $error("unexpected result item: success %0b expired %0b", got.success, got.expired);
        faults++;
        return;
      end
      want = outcome_q.pop_front();
      if (got.success !== want.success) begin
        $error("success: expected %0b, got %0b", want.success, got.success);
        faults++;
      end
      if (got.expired !== want.expired) begin
        $error("expired: expected %0b, got %0b", want.expired, got.expired);
        faults++;
      end
    endfunction

    function int pending();
      return outcome_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_item;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  session_scoreboard sb;
  bit                sender_quiet;

  always #5 clk = ~clk;

  session_table_with_expiry u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  function automatic in_item_t make_item(logic [1:0] op, logic [KEY_W-1:0] key,
                                         logic [TIME_W-1:0] now);
    in_item_t item;
    item.operation = op;
    {item.net_number, item.station_number, item.port_number} = key;
    item.now_seconds = now;
    return item;
  endfunction

  // keys used to fill the table; the last one repeats the first
  function automatic logic [KEY_W-1:0] fill_key(int i);
    if (i == 0 || i == TABLE_ENTRIES - 1) return 24'h000001;
    if (i == 1) return 24'h010000;
    if (i == 2) return 24'h000100;
    return {8'(i * 37 + 11), 8'(8'hC3 ^ i), 8'(i)};
  endfunction

  task automatic send_item(input in_item_t item);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 11);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_item(item);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_lifetime(input logic [LIFE_W-1:0] value);
    logic [CFG_DATA_W-1:0] readback;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'(4 * int'(REG_LIFETIME));
    pwdata <= {16'($urandom_range(0, 65535)), value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.lifetime = value;
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    readback = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (readback[LIFE_W-1:0] !== value) begin
      $error("session_lifetime: expected %0d, got %0d", value, readback[LIFE_W-1:0]);
      sb.faults++;
    end
  endtask

  initial begin : result_sink
    int stall;
    int taken;
    bit quiet;
    taken = 0;
    quiet = 1'b0;
    out_ready = 1'b0;
    forever begin
      if (taken % 32 == 0) quiet = ($urandom_range(0, 3) == 0);
      stall = quiet ? 0 : $urandom_range(0, 11);
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (rst || out_valid !== 1'b1);
      sb.check_result(out_item);
      taken++;
    end
  end

  initial begin : stimulus
    logic [KEY_W-1:0]  key_pool [POOL_SIZE];
    logic [LIFE_W-1:0] lifetimes [5];
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] span;
    logic [KEY_W-1:0]  key;
    logic [1:0]        op;
    int                pick;
    sb = new();
    sender_quiet = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // zero key, unused code and misses
    now = 32'd1000;
    send_item(make_item(OP_START, '0, now));
    send_item(make_item(OP_LOOKUP, '0, now));
    send_item(make_item(OP_END, '0, now));
    send_item(make_item(OP_UNUSED, 24'h010203, now));
    send_item(make_item(OP_LOOKUP, 24'h010203, now));
    send_item(make_item(OP_END, 24'h010203, now));
    // deadline wraps past zero, so the session is already stale
    send_item(make_item(OP_START, 24'hFFFFFF, 32'hFFFF_FFFF));
    send_item(make_item(OP_LOOKUP, 24'hFFFFFF, 32'hFFFF_FFFF));
    // fill the table, with one duplicate key, then overflow it
    for (int i = 0; i < TABLE_ENTRIES; i++) send_item(make_item(OP_START, fill_key(i), '0));
    send_item(make_item(OP_START, 24'h123456, '0));
    send_item(make_item(OP_LOOKUP, fill_key(1), TIME_W'(LIFETIME_RESET)));
    send_item(make_item(OP_LOOKUP, fill_key(2), TIME_W'(LIFETIME_RESET) + 1));
    send_item(make_item(OP_END, fill_key(0), 32'd5));
    send_item(make_item(OP_LOOKUP, fill_key(0), 32'd5));

    // pool keeps the directed keys so that leftover entries can still be freed
    for (int p = 0; p < POOL_SIZE; p++) begin
      key_pool[p] = (p < TABLE_ENTRIES) ? fill_key(p) : KEY_W'($urandom());
      if (key_pool[p] == '0) key_pool[p] = 24'h800000;
    end
    lifetimes[0] = 16'hFFFF;
    lifetimes[1] = 16'h0000;
    lifetimes[2] = 16'h0001;
    lifetimes[3] = 16'($urandom_range(2, 65534));
    lifetimes[4] = LIFETIME_RESET;
    now = $urandom();

    for (int ph = 0; ph < 5; ph++) begin
      wait_drained();
      write_lifetime(lifetimes[ph]);
      span = (TIME_W'(lifetimes[ph]) >> 3) + 3;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        sender_quiet = (n % 64) < 12;
        pick = $urandom_range(0, 99);
        if (pick < 40) op = OP_START;
        else if (pick < 75) op = OP_LOOKUP;
        else if (pick < 95) op = OP_END;
        else op = OP_UNUSED;
        pick = $urandom_range(0, 99);
        if (pick < 3) key = '0;
        else if (pick < 12) key = KEY_W'($urandom());
        else key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        // mostly forward steps in time, now and then a jump anywhere
        if ($urandom_range(0, 99) < 5) now = $urandom();
        else now = now + $urandom_range(0, span);
        send_item(make_item(op, key, now));
      end
    end
    wait_drained();

    $display("covered %0d items over five session lifetimes: %0d opened, %0d refused as full",
             sb.items, sb.opened, sb.refused);
    $display("lookups found %0d live and %0d expired sessions, %0d sessions ended",
             sb.live, sb.expiries, sb.ended);
    if (sb.pending() != 0) $error("%0d expected results never arrived", sb.pending());
    if (sb.faults == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
